@@ design/bmp_pixel_to_xrgb_converter_defines.svh @@
// Assertion macros shared by the converter RTL.
`ifndef BMP_PIXEL_TO_XRGB_CONVERTER_DEFINES_SVH
`define BMP_PIXEL_TO_XRGB_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define BMPX_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Implication checked in the same cycle.
`define BMPX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked in the next cycle.
`define BMPX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BMPX_ASSERT_ALWAYS(lbl, cond, msg)
`define BMPX_ASSERT_SAME(lbl, ante, cons, msg)
`define BMPX_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/bmpx_pkg.sv @@
// Types and constants of the BMP pixel to XRGB converter.
package bmpx_pkg;

  localparam int PaletteEntries = 256;
  localparam int PaletteIdxW    = 8;
  localparam int CfgDimW        = 13;
  localparam int CfgDataW       = 13;
  localparam int CfgIndexW      = 2;
  localparam int FbCoordW       = 12;
  localparam int PixelW         = 24;
  localparam int WordW          = 32;

  // Register indexes on the configuration port.
  localparam logic [CfgIndexW-1:0] RegPixelFormat = 2'd0;
  localparam logic [CfgIndexW-1:0] RegImageWidth  = 2'd1;
  localparam logic [CfgIndexW-1:0] RegImageHeight = 2'd2;

  // Pixel format codes; the spare code behaves as 24bpp.
  localparam logic [1:0] FmtPalette = 2'd0;
  localparam logic [1:0] FmtRgb565  = 2'd1;
  localparam logic [1:0] FmtBgr24   = 2'd2;

  // Item kinds on the input stream.
  localparam logic KindPalette = 1'b0;
  localparam logic KindPixel   = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [PaletteIdxW-1:0] palette_index;
    logic [WordW-1:0]       palette_word;
    logic [PixelW-1:0]      pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [FbCoordW-1:0] fb_row;
    logic [FbCoordW-1:0] fb_column;
    logic [WordW-1:0]    fb_word;
    logic                frame_done;
  } out_word_t;

  // Framebuffer position of the current pixel, from the raster counters.
  typedef struct packed {
    logic [FbCoordW-1:0] row;
    logic [FbCoordW-1:0] column;
    logic                done;
  } pos_t;

endpackage

@@ design/bmpx_stream_if.sv @@
// Valid/ready stream interface carrying one word per handshake.
interface bmpx_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/bmpx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bmpx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/bmpx_raster.sv @@
// Column and row counters that map file order onto a vertically flipped framebuffer.
module bmpx_raster #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [bmpx_pkg::CfgDimW-1:0] image_width,
  input  logic [bmpx_pkg::CfgDimW-1:0] image_height,
  output bmpx_pkg::pos_t              pos
);

  localparam int CW   = $clog2(MAX_DIMENSION);
  localparam int CmpW = (bmpx_pkg::CfgDimW > CW + 1) ? bmpx_pkg::CfgDimW : CW + 1;

  logic [CW-1:0] column_count, column_count_next;
  logic [CW-1:0] rows_done, rows_done_next;
  logic [CW-1:0] w_last, h_last;
  logic          row_end, last_row;

  // Last index of a dimension: zero is taken as one, oversize as the maximum.
  function automatic logic [CW-1:0] last_index(input logic [bmpx_pkg::CfgDimW-1:0] v);
    logic [CmpW-1:0] ext;
    ext = CmpW'(v);
    priority if (ext == '0) begin
      return '0;
    end else if (ext > CmpW'(MAX_DIMENSION)) begin
      return CW'(MAX_DIMENSION - 1);
    end else begin
      return CW'(ext - CmpW'(1));
    end
  endfunction

  always_comb begin
    w_last   = last_index(image_width);
    h_last   = last_index(image_height);
    row_end  = (column_count >= w_last);
    last_row = (rows_done >= h_last);

    pos.row    = last_row ? '0 : bmpx_pkg::FbCoordW'(h_last - rows_done);
    pos.column = bmpx_pkg::FbCoordW'(column_count);
    pos.done   = row_end && last_row;

    column_count_next = column_count;
    rows_done_next    = rows_done;
    if (step) begin
      if (row_end) begin
        column_count_next = '0;
        rows_done_next    = last_row ? '0 : rows_done + CW'(1);
      end else begin
        column_count_next = column_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      rows_done    <= '0;
    end else begin
      column_count <= column_count_next;
      rows_done    <= rows_done_next;
    end
  end

endmodule

@@ design/bmp_pixel_to_xrgb_converter.sv @@
// Top level of the BMP pixel to XRGB converter.
//
//   Port   Dir  Handshake          Content
//   bmp    in   valid/ready        palette write or raw pixel word, file order
//   fb     out  valid/ready        framebuffer row, column, XRGB word, frame end
//   cfg    in   cfg_write strobe   pixel_format, image_width, image_height
//
// One word is taken every cycle while the output side keeps up; a pixel's
// result is registered by the palette RAM read and stage one, then by the
// conversion into the output register. Palette writes produce no result.
// Reset is synchronous and clears the raster counters, the valid flags and
// the registers to 24bpp, 480 by 800; the palette RAM is not cleared.
// Input ready falls only when both stages are full and the output is stalled.
`include "bmp_pixel_to_xrgb_converter_defines.svh"

module bmp_pixel_to_xrgb_converter #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  bmpx_stream_if.sink                      bmp,
  bmpx_stream_if.source                    fb,
  input  logic                             cfg_write,
  input  logic [bmpx_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [bmpx_pkg::CfgDataW-1:0]    cfg_data
);

  // Configuration registers.
  logic [1:0]                     pixel_format;
  logic [bmpx_pkg::CfgDimW-1:0]   image_width;
  logic [bmpx_pkg::CfgDimW-1:0]   image_height;

  // Handshake and pipeline control.
  logic accept, accept_pixel, accept_palette;
  logic s1_valid, s1_adv;
  logic out_valid;

  // Stage one holds the pixel while the palette RAM read completes.
  bmpx_pkg::pos_t                 pos;
  bmpx_pkg::pos_t                 s1_pos;
  logic [bmpx_pkg::PixelW-1:0]    s1_pixel;
  logic [1:0]                     s1_format;
  logic [bmpx_pkg::WordW-1:0]     palette_data;
  logic [bmpx_pkg::WordW-1:0]     word_next;
  bmpx_pkg::in_word_t             in_word;
  bmpx_pkg::out_word_t            out_word;

  assign in_word        = bmp.payload;
  assign accept         = bmp.valid && bmp.ready;
  assign accept_pixel   = accept && (in_word.kind == bmpx_pkg::KindPixel);
  assign accept_palette = accept && (in_word.kind == bmpx_pkg::KindPalette);

  // Stage one moves on when the output register is empty or being emptied.
  assign s1_adv    = s1_valid && (!out_valid || fb.ready);
  assign bmp.ready = !s1_valid || s1_adv;

  assign fb.valid   = out_valid;
  assign fb.payload = out_word;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= bmpx_pkg::FmtBgr24;
      image_width  <= bmpx_pkg::CfgDimW'(480);
      image_height <= bmpx_pkg::CfgDimW'(800);
    end else if (cfg_write) begin
      unique case (cfg_index)
        bmpx_pkg::RegPixelFormat: pixel_format <= cfg_data[1:0];
        bmpx_pkg::RegImageWidth:  image_width  <= cfg_data;
        bmpx_pkg::RegImageHeight: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // The raster counters step once for every pixel taken, never for a palette write.
  bmpx_raster #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_raster (
    .clk          (clk),
    .rst          (rst),
    .step         (accept_pixel),
    .image_width  (image_width),
    .image_height (image_height),
    .pos          (pos)
  );

  // Palette: written by palette words, read at the index of every pixel taken.
  // The read data is held while stage one stalls, as the read only fires on accept.
  bmpx_ram #(
    .WIDTH (bmpx_pkg::WordW),
    .DEPTH (bmpx_pkg::PaletteEntries)
  ) u_palette (
    .clk   (clk),
    .we    (accept_palette),
    .waddr (in_word.palette_index),
    .wdata (in_word.palette_word),
    .re    (accept_pixel),
    .raddr (in_word.pixel_value[bmpx_pkg::PaletteIdxW-1:0]),
    .rdata (palette_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= accept_pixel;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_pixel) begin
      s1_pos    <= pos;
      s1_pixel  <= in_word.pixel_value;
      s1_format <= pixel_format;
    end
  end

  // Pixel conversion. RGB565 channels are shifted up with the low bits zero;
  // the palette word passes on whole, reserved byte included.
  always_comb begin
    unique case (s1_format)
      bmpx_pkg::FmtPalette: word_next = palette_data;
      bmpx_pkg::FmtRgb565:  word_next = {8'h00,
                                         s1_pixel[15:11], 3'b000,
                                         s1_pixel[10:5],  2'b00,
                                         s1_pixel[4:0],   3'b000};
      default:              word_next = {8'h00, s1_pixel};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (fb.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word.fb_row     <= s1_pos.row;
      out_word.fb_column  <= s1_pos.column;
      out_word.fb_word    <= word_next;
      out_word.frame_done <= s1_pos.done;
    end
  end

  // A pixel taken is always held in stage one on the next cycle.
  `BMPX_ASSERT_NEXT(a_pixel_enters_s1, accept_pixel, s1_valid, "pixel lost after accept")
  // A full pipeline with a stalled output must not take another word.
  `BMPX_ASSERT_SAME(a_full_blocks_input, s1_valid && out_valid && !fb.ready, !bmp.ready,
                    "input taken while pipeline is full")
  // A stalled stage one keeps its pixel.
  `BMPX_ASSERT_NEXT(a_s1_holds, s1_valid && !s1_adv && !accept, s1_valid,
                    "stage one dropped a stalled pixel")
  // The last pixel of a frame always lands on the top framebuffer row.
  `BMPX_ASSERT_ALWAYS(a_done_on_top_row, !(out_valid && out_word.frame_done) ||
                      (out_word.fb_row == '0), "frame end off the top row")

endmodule
